FILE: hdl/swfr_pkg.sv
package swfr_pkg;

    // wrapping frame counters
    localparam int CNT_W      = 32;
    localparam int OUT_CNT_W  = 32;

    localparam int SYNC_LEN    = 5;
    localparam int PAYLOAD_LEN = 9;
    localparam int SYNC_POS_W  = $clog2(SYNC_LEN + 1);
    localparam int PAY_POS_W   = $clog2(PAYLOAD_LEN + 1);

    localparam logic [7:0] XOR_SEED = 8'h55;

    localparam logic [7:0] SYNC_C = 8'h43;
    localparam logic [7:0] SYNC_B = 8'h42;
    localparam logic [7:0] SYNC_A = 8'h41;
    localparam logic [7:0] SYNC_L = 8'h4C;

    // result kinds
    localparam logic KIND_GOOD = 1'b0;
    localparam logic KIND_BAD  = 1'b1;

    // payload byte places
    localparam int P_COUNT    = 0;
    localparam int P_RECEIVED = 1;
    localparam int P_STATUS   = 2;
    localparam int P_DIGITAL  = 3;
    localparam int P_MOTOR    = 4;
    localparam int P_ANALOG0  = 5;
    localparam int P_ANALOG1  = 6;
    localparam int P_ANALOG2  = 7;
    localparam int P_ANALOG3  = 8;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_CHECK
    } swfr_phase_t;

    typedef struct packed {
        logic                             fire;
        logic                             kind;
        logic [PAYLOAD_LEN-1:0][7:0]      payload;
        logic [CNT_W-1:0]                 good;
        logic [CNT_W-1:0]                 bad;
    } swfr_result_t;

    // expected byte of the sync word at a given position
    function automatic logic [7:0] sync_char(input logic [SYNC_POS_W-1:0] pos);
        logic [7:0] ch;
        begin
            unique case (pos)
                SYNC_POS_W'(0): ch = SYNC_C;
                SYNC_POS_W'(1): ch = SYNC_B;
                SYNC_POS_W'(2): ch = SYNC_A;
                SYNC_POS_W'(3): ch = SYNC_L;
                SYNC_POS_W'(4): ch = SYNC_L;
                default:        ch = SYNC_C;
            endcase
            return ch;
        end
    endfunction

endpackage

FILE: hdl/swfr_parser.sv
module swfr_parser
    import swfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output swfr_result_t res
);

    swfr_phase_t              phase_reg, phase_next;
    logic [SYNC_POS_W-1:0]    sync_pos_reg, sync_pos_next;
    logic [PAY_POS_W-1:0]     pay_pos_reg, pay_pos_next;
    logic [7:0]               xor_reg, xor_next;
    logic [7:0]               last_count_reg, last_count_next;
    logic                     last_valid_reg, last_valid_next;
    logic [CNT_W-1:0]         good_reg, good_next;
    logic [CNT_W-1:0]         bad_reg, bad_next;
    logic [PAYLOAD_LEN-1:0][7:0] store_reg;

    logic sum_ok;
    logic is_new;

    assign sum_ok = (rx_byte == xor_reg);
    assign is_new = !last_valid_reg || (store_reg[P_COUNT] != last_count_reg);

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        sync_pos_next = sync_pos_reg;
        pay_pos_next  = pay_pos_reg;
        xor_next      = xor_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == sync_char(sync_pos_reg))
                begin
                    if (sync_pos_reg == SYNC_POS_W'(SYNC_LEN - 1))
                    begin
                        phase_next    = PH_PAYLOAD;
                        sync_pos_next = '0;
                    end
                    else
                    begin
                        sync_pos_next = sync_pos_reg + 1'b1;
                    end
                end
                else if (rx_byte == SYNC_C)
                begin
                    sync_pos_next = SYNC_POS_W'(1);
                end
                else
                begin
                    sync_pos_next = '0;
                end
            end
            PH_PAYLOAD:
            begin
                xor_next = xor_reg ^ rx_byte;
                if (pay_pos_reg == PAY_POS_W'(PAYLOAD_LEN - 1))
                begin
                    phase_next   = PH_CHECK;
                    pay_pos_next = '0;
                end
                else
                begin
                    pay_pos_next = pay_pos_reg + 1'b1;
                end
            end
            PH_CHECK:
            begin
                phase_next = PH_HUNT;
                xor_next   = XOR_SEED;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // outputs and frame bookkeeping
    always_comb
    begin
        res             = '0;
        last_count_next = last_count_reg;
        last_valid_next = last_valid_reg;
        good_next       = good_reg;
        bad_next        = bad_reg;
        res.good        = good_reg;
        res.bad         = bad_reg;
        unique case (phase_reg)
            PH_CHECK:
            begin
                if (!sum_ok)
                begin
                    bad_next = bad_reg + 1'b1;
                    res.fire = 1'b1;
                    res.kind = KIND_BAD;
                    res.bad  = bad_next;
                end
                else if (is_new)
                begin
                    good_next       = good_reg + 1'b1;
                    last_count_next = store_reg[P_COUNT];
                    last_valid_next = 1'b1;
                    res.fire        = 1'b1;
                    res.kind        = KIND_GOOD;
                    res.payload     = store_reg;
                    res.good        = good_next;
                end
            end
            PH_HUNT, PH_PAYLOAD:
            begin
                res.fire = 1'b0;
            end
            default:
            begin
                res.fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            sync_pos_reg   <= '0;
            pay_pos_reg    <= '0;
            xor_reg        <= XOR_SEED;
            last_count_reg <= '0;
            last_valid_reg <= 1'b0;
            good_reg       <= '0;
            bad_reg        <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            sync_pos_reg   <= sync_pos_next;
            pay_pos_reg    <= pay_pos_next;
            xor_reg        <= xor_next;
            last_count_reg <= last_count_next;
            last_valid_reg <= last_valid_next;
            good_reg       <= good_next;
            bad_reg        <= bad_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (step && (phase_reg == PH_PAYLOAD))
        begin
            store_reg[pay_pos_reg] <= rx_byte;
        end
    end

    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (pay_pos_reg == '0 && xor_reg == XOR_SEED))
        else $error("hunt phase with stale frame state");

    a_fire_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        res.fire |-> (phase_reg == PH_CHECK))
        else $error("result outside checksum byte");

    a_good_step: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.fire && res.kind == KIND_GOOD) |=>
            (good_reg == $past(good_reg) + 1'b1 && bad_reg == $past(bad_reg)))
        else $error("good counter out of step");

    a_repeat_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_CHECK && sum_ok && !is_new) |-> !res.fire)
        else $error("repeated count produced a result");

endmodule

FILE: hdl/sync_word_frame_receiver.sv
// sync word frame receiver
// byte channel: one received serial byte per item on rx_byte, qualified by
//   byte_valid and held off by byte_stall
// result channel: result_valid / result_stall with one port per field; an
//   item appears only on the checksum byte of a frame that either fails its
//   checksum (frame_kind 1, payload fields zero) or carries a new count
//   (frame_kind 0, all nine payload bytes)
// good_count and error_count are the wrapping frame counters after this
//   frame is counted
// the block hunts for the sync word C,B,A,L,L, then takes nine payload bytes
//   and a checksum byte equal to 0x55 xor the payload
// a byte taken into the input register is decoded from there into the result
//   register, from which its result is taken
// throughput: one byte per cycle while the result side does not stall, set by
//   the single decode stage between the input register and the result register
// reset clears the hunt, the counters and the last-count memory at once;
//   no sweep follows, bytes are taken from the first cycle
// a stalled result holds and decoding waits for it; the input register takes
//   one more byte, then byte_stall stays high until the result is taken
module sync_word_frame_receiver
    import swfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  logic [7:0]           rx_byte,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 frame_kind,
    output logic [7:0]           seq_count,
    output logic [7:0]           seq_acked,
    output logic [7:0]           status_byte,
    output logic [7:0]           digital_in,
    output logic [7:0]           motor_in,
    output logic [7:0]           analog_zero,
    output logic [7:0]           analog_one,
    output logic [7:0]           analog_two,
    output logic [7:0]           analog_three,
    output logic [OUT_CNT_W-1:0] good_count,
    output logic [OUT_CNT_W-1:0] error_count
);

    // input register
    logic         in_full_reg, in_full_next;
    logic [7:0]   in_byte_reg;

    // result register
    logic         res_valid_reg, res_valid_next;
    swfr_result_t res_reg;

    swfr_result_t dec_res;
    logic         drain_ok;
    logic         advance;
    logic         take;

    // the result slot is free, or is being emptied this cycle
    assign drain_ok   = !res_valid_reg || !result_stall;
    assign advance    = in_full_reg && drain_ok;
    assign byte_stall = in_full_reg && !drain_ok;
    assign take       = byte_valid && !byte_stall;

    swfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res     (dec_res)
    );

    always_comb
    begin
        if (take)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
        else
        begin
            in_full_next = in_full_reg;
        end
    end

    always_comb
    begin
        if (advance && dec_res.fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && dec_res.fire)
        begin
            res_reg <= dec_res;
        end
    end

    assign result_valid = res_valid_reg;
    assign frame_kind   = res_reg.kind;
    assign seq_count    = res_reg.payload[P_COUNT];
    assign seq_acked    = res_reg.payload[P_RECEIVED];
    assign status_byte  = res_reg.payload[P_STATUS];
    assign digital_in   = res_reg.payload[P_DIGITAL];
    assign motor_in     = res_reg.payload[P_MOTOR];
    assign analog_zero  = res_reg.payload[P_ANALOG0];
    assign analog_one   = res_reg.payload[P_ANALOG1];
    assign analog_two   = res_reg.payload[P_ANALOG2];
    assign analog_three = res_reg.payload[P_ANALOG3];
    assign good_count   = OUT_CNT_W'(res_reg.good);
    assign error_count  = OUT_CNT_W'(res_reg.bad);

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_stall) |-> !(advance && dec_res.fire))
        else $error("pending result overwritten");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (in_full_reg && res_valid_reg))
        else $error("input held off with room to spare");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_kind == KIND_BAD) |-> (seq_count == 8'h00))
        else $error("error item carries payload");

endmodule

FILE: tb/swfr_checker.sv
module swfr_checker
    import swfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic                 byte_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  logic                 frame_kind,
    input  logic [7:0]           seq_count,
    input  logic [7:0]           seq_acked,
    input  logic [7:0]           status_byte,
    input  logic [7:0]           digital_in,
    input  logic [7:0]           motor_in,
    input  logic [7:0]           analog_zero,
    input  logic [7:0]           analog_one,
    input  logic [7:0]           analog_two,
    input  logic [7:0]           analog_three,
    input  logic [OUT_CNT_W-1:0] good_count,
    input  logic [OUT_CNT_W-1:0] error_count,
    output int                   frame_faults,
    output int                   reports_owed,
    output int                   reports_checked,
    output int                   checksum_errors,
    output int                   repeats_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        kind;
        logic [PAYLOAD_LEN-1:0][7:0] body;
        logic [OUT_CNT_W-1:0]        good;
        logic [OUT_CNT_W-1:0]        bad;
    } frame_report_t;

    localparam logic [7:0] SYNC_SEQ [SYNC_LEN] = '{SYNC_C, SYNC_B, SYNC_A, SYNC_L, SYNC_L};
    localparam int SHOWN_MAX = 10;

    string body_name [PAYLOAD_LEN] = '{"seq_count", "seq_acked", "status_byte",
        "digital_in", "motor_in", "analog_zero", "analog_one", "analog_two", "analog_three"};

    // receiver state as predicted
    int                          sync_seen;
    int                          body_seen;
    logic [PAYLOAD_LEN-1:0][7:0] body_bytes;
    logic [7:0]                  xor_acc;
    logic [7:0]                  count_last;
    bit                          count_known;
    logic [CNT_W-1:0]            good_frames;
    logic [CNT_W-1:0]            bad_frames;

    frame_report_t owed_q [$];
    int faults;
    int checked;
    int errors;
    int repeats;

    frame_report_t seen;

    assign seen = {frame_kind, analog_three, analog_two, analog_one, analog_zero, motor_in,
                   digital_in, status_byte, seq_acked, seq_count, good_count, error_count};

    // advances the predicted receiver by one byte, returns 1 when a report is due
    function automatic bit decode_byte(input logic [7:0] b, output frame_report_t rep);
        bit fires;
        fires = 1'b0;
        rep = '0;
        if (sync_seen < SYNC_LEN)
        begin
            if (b == SYNC_SEQ[sync_seen])
                sync_seen++;
            else
                sync_seen = (b == SYNC_C) ? 1 : 0;
        end
        else if (body_seen < PAYLOAD_LEN)
        begin
            body_bytes[body_seen] = b;
            xor_acc ^= b;
            body_seen++;
        end
        else
        begin
            if (b == xor_acc)
            begin
                if (!count_known || body_bytes[P_COUNT] != count_last)
                begin
                    count_last = body_bytes[P_COUNT];
                    count_known = 1'b1;
                    good_frames++;
                    rep.kind = KIND_GOOD;
                    rep.body = body_bytes;
                    fires = 1'b1;
                end
                else
                    repeats++;
            end
            else
            begin
                bad_frames++;
                errors++;
                rep.kind = KIND_BAD;
                fires = 1'b1;
            end
            rep.good = good_frames[OUT_CNT_W-1:0];
            rep.bad = bad_frames[OUT_CNT_W-1:0];
            sync_seen = 0;
            body_seen = 0;
            xor_acc = XOR_SEED;
        end
        return fires;
    endfunction

    function automatic string describe(input frame_report_t r);
        string s;
        s = $sformatf("kind %0d", r.kind);
        for (int i = 0; i < PAYLOAD_LEN; i++)
            s = {s, $sformatf(" %s %02h", body_name[i], r.body[i])};
        return {s, $sformatf(" good %0d errors %0d", r.good, r.bad)};
    endfunction

    function automatic string field_diff(input frame_report_t want, input frame_report_t got);
        string d;
        d = "";
        if (want.kind !== got.kind)
            d = {d, " frame_kind"};
        for (int i = 0; i < PAYLOAD_LEN; i++)
            if (want.body[i] !== got.body[i])
                d = {d, " ", body_name[i]};
        if (want.good !== got.good)
            d = {d, " good_count"};
        if (want.bad !== got.bad)
            d = {d, " error_count"};
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_report_t want;
        frame_report_t rep;
        string         diff;
        if (!rst_n)
        begin
            sync_seen = 0;
            body_seen = 0;
            body_bytes = '0;
            xor_acc = XOR_SEED;
            count_last = 8'h00;
            count_known = 1'b0;
            good_frames = '0;
            bad_frames = '0;
            owed_q.delete();
            frame_faults <= 0;
            reports_owed <= 0;
            reports_checked <= 0;
            checksum_errors <= 0;
            repeats_dropped <= 0;
        end
        else
        begin
            // a byte taken now cannot report at this same edge, so check first
            if (result_valid && !result_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    faults++;
                    if (faults <= SHOWN_MAX)
                        $display("%0t: unexpected report: %s", $time, describe(seen));
                end
                else
                begin
                    want = owed_q.pop_front();
                    checked++;
                    diff = field_diff(want, seen);
                    if (diff != "")
                    begin
                        faults++;
                        if (faults <= SHOWN_MAX)
                            $display("%0t: report mismatch in%s\n  expected %s\n  actual   %s",
                                     $time, diff, describe(want), describe(seen));
                    end
                end
            end
            if (byte_valid && !byte_stall)
            begin
                if (decode_byte(rx_byte, rep))
                    owed_q.push_back(rep);
            end
            frame_faults <= faults;
            reports_owed <= owed_q.size();
            reports_checked <= checked;
            checksum_errors <= errors;
            repeats_dropped <= repeats;
        end
    end

endmodule

FILE: tb/tb.sv
module tb
    import swfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // roughly this many serial bytes in all, spread over four idling mixes
    localparam int TOTAL_BYTES = 1050;
    localparam int MIX_BYTES   = (TOTAL_BYTES + 3) / 4;
    // cycles with nothing taken on either side before the run is called hung
    localparam int QUIET_LIMIT = 2000;
    // leave a margin after the last drain for a stray extra report
    localparam int SETTLE_CYCLES = 8;

    localparam logic [7:0] SYNC_SEQ [SYNC_LEN] = '{SYNC_C, SYNC_B, SYNC_A, SYNC_L, SYNC_L};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // byte side, driven here
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] rx_byte = 8'h00;

    // report side, stalled here
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic                 frame_kind;
    logic [7:0]           seq_count;
    logic [7:0]           seq_acked;
    logic [7:0]           status_byte;
    logic [7:0]           digital_in;
    logic [7:0]           motor_in;
    logic [7:0]           analog_zero;
    logic [7:0]           analog_one;
    logic [7:0]           analog_two;
    logic [7:0]           analog_three;
    logic [OUT_CNT_W-1:0] good_count;
    logic [OUT_CNT_W-1:0] error_count;

    // figures handed back by the checker
    int frame_faults;
    int reports_owed;
    int reports_checked;
    int checksum_errors;
    int repeats_dropped;

    // idling mix: percentage of cycles the sender sits idle / the receiver stalls
    int idle_pct = 0;
    int stall_pct = 0;

    int bytes_sent = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sync_word_frame_receiver dut (.*);

    swfr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .rx_byte         (rx_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .frame_kind      (frame_kind),
        .seq_count       (seq_count),
        .seq_acked       (seq_acked),
        .status_byte     (status_byte),
        .digital_in      (digital_in),
        .motor_in        (motor_in),
        .analog_zero     (analog_zero),
        .analog_one      (analog_one),
        .analog_two      (analog_two),
        .analog_three    (analog_three),
        .good_count      (good_count),
        .error_count     (error_count),
        .frame_faults    (frame_faults),
        .reports_owed    (reports_owed),
        .reports_checked (reports_checked),
        .checksum_errors (checksum_errors),
        .repeats_dropped (repeats_dropped)
    );

    // receiver back-pressure, redrawn every cycle from the current mix
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // watchdog: a run of cycles with no item moved on either side means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("hung: no item moved for %0d cycles", QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // byte values skewed towards the edges and the sync characters
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return SYNC_C;
            3: return SYNC_L;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // offers one item, with random idle cycles first, and returns once it is taken;
    // valid is only ever assigned once per edge so it never glitches low between items
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // nine payload bytes then the checksum, optionally spoilt
    task automatic send_body(input logic [PAYLOAD_LEN-1:0][7:0] body, input bit corrupt);
        logic [7:0] sum;
        sum = XOR_SEED;
        for (int i = 0; i < PAYLOAD_LEN; i++)
        begin
            send_byte(body[i]);
            sum ^= body[i];
        end
        if (corrupt)
            sum ^= 8'($urandom_range(255, 1));
        send_byte(sum);
    endtask

    // line noise between frames: sometimes a sync prefix cut short, then stray bytes
    task automatic send_noise();
        int run;
        if ($urandom_range(1))
        begin
            run = $urandom_range(SYNC_LEN - 1, 1);
            for (int k = 0; k < run; k++)
                send_byte(SYNC_SEQ[k]);
        end
        run = $urandom_range(3, 1);
        for (int k = 0; k < run; k++)
            send_byte(pick_byte());
    endtask

    // sender holds off until every owed report has been taken; the first edge
    // lets the checker catch up with the item taken at the last one
    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (reports_owed != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [PAYLOAD_LEN-1:0][7:0] body;
        logic [7:0]                  count;
        logic [7:0]                  last_good_count;
        bit                          corrupt;

        last_good_count = 8'h00;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: hunt broken by a stray byte, then broken by a fresh 'C'
        send_byte(SYNC_C);
        send_byte(SYNC_B);
        send_byte(8'h5A);
        send_byte(SYNC_C);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        send_byte(SYNC_C);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        send_byte(SYNC_L);
        send_byte(SYNC_L);
        // first frame after reset: extremes and a whole sync word inside the payload
        body = {8'h01, 8'h80, SYNC_L, SYNC_L, SYNC_A, SYNC_B, SYNC_C, 8'hFF, 8'h00};
        send_body(body, 1'b0);
        last_good_count = body[P_COUNT];
        drain();

        // random frames under each idling mix: none, sender idle, receiver stalling, both
        for (int mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            while (bytes_sent < (mix + 1) * MIX_BYTES)
            begin
                if ($urandom_range(99) < 25)
                    send_noise();
                for (int i = 0; i < PAYLOAD_LEN; i++)
                    body[i] = pick_byte();
                // about a quarter of frames repeat the last good count; unspoilt ones should be swallowed
                count = ($urandom_range(99) < 25) ? last_good_count : 8'($urandom_range(255));
                body[P_COUNT] = count;
                corrupt = ($urandom_range(99) < 15);
                for (int k = 0; k < SYNC_LEN; k++)
                    send_byte(SYNC_SEQ[k]);
                send_body(body, corrupt);
                if (!corrupt)
                    last_good_count = count;
            end
            // full pause between mixes so the pipeline empties with the sender quiet
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d bytes under four idling mixes: %0d reports checked, %0d bad checksums",
                 bytes_sent, reports_checked, checksum_errors);
        $display("%0d repeated counts dropped, %0d faults, %0d reports still owed",
                 repeats_dropped, frame_faults, reports_owed);
        if (frame_faults == 0 && reports_owed == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
hdl/swfr_pkg.sv
hdl/swfr_parser.sv
hdl/sync_word_frame_receiver.sv
tb/swfr_checker.sv
tb/tb.sv
